### src/swlru_pkg.sv
// shared constants, codes and state type of the byte-weighted lru table
package swlru_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 32;
  localparam int unsigned KEY_BITS_DEF    = 48;
  localparam int unsigned SIZE_BITS_DEF   = 40;
  localparam int unsigned LIMIT_BITS      = 40;
  localparam int unsigned CMD_BITS        = 3;
  localparam int unsigned STATUS_BITS     = 2;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 40'd1073741824;

  localparam logic [CMD_BITS-1:0] CMD_ADD     = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_REFRESH = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_BEGIN   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_END     = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_SPACE   = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_DUP       = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EVICT  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_CMP,
    S_DEC,
    S_SU_RD,
    S_SU_WR,
    S_WR_FRONT,
    S_SD_RD,
    S_SD_WR,
    S_DIV,
    S_TGT,
    S_EV_CHK,
    S_EV_OUT,
    S_EMIT
  } state_t;

endpackage

### src/swlru_ram.sv
// generic simple dual-port ram with registered read
module swlru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/swlru_div5.sv
// division of the footprint limit by five through a shift-add reciprocal multiply
module swlru_div5 (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [swlru_pkg::LIMIT_BITS-1:0]   dividend,
  output logic                               done,
  output logic [swlru_pkg::LIMIT_BITS-1:0]   quotient
);

  // q = floor(x * (T + 1) / 2^44), T = (2^44 - 1) / 5 = 3 * (1 + 2^4 + ... + 2^40)
  // exact for every 40-bit x; the term count follows LIMIT_BITS = 40
  localparam int unsigned XB = swlru_pkg::LIMIT_BITS;
  localparam int unsigned QS = 44;
  localparam int unsigned PW = XB + QS;

  logic [4:0]    stg_r;
  logic [PW-1:0] x_r;
  logic [PW-1:0] a_r;
  logic [PW-1:0] b_r;
  logic [PW-1:0] c_r;
  logic [PW-1:0] d_r;
  logic [PW-1:0] e_r;
  logic [PW-1:0] p_r;

  // one stage flag per pipeline step, done rises as the product register is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else if (start) begin
      stg_r <= 5'b00001;
    end else begin
      stg_r <= {stg_r[3:0], 1'b0};
    end
  end

  // operands are held after start, so every later stage settles and stays
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= PW'(dividend);
      a_r <= PW'(dividend) + (PW'(dividend) << 1);
    end
    b_r <= a_r + (a_r << 4);
    c_r <= b_r + (b_r << 8);
    d_r <= c_r + (c_r << 16);
    e_r <= (b_r << 32) + (a_r << 40) + x_r;
    p_r <= d_r + e_r;
  end

  assign done     = stg_r[4];
  assign quotient = p_r[PW-1:QS];

endmodule

### src/size_weighted_lru_eviction_top.sv
// byte-weighted lru eviction table: control sequencer around the entry ram
//
// usage: requests enter on in_valid/in_ready, results leave on out_valid/out_ready,
// the footprint limit is written through cfg_wr_en/cfg_wr_data while idle.
// entries are held in one ram in recency order: address 0 is the most recent and
// address count-1 the least recent, so eviction always reads the tail.
// every request but a space request gives one result, a space request gives one
// result per evicted object and then a status result (last marks the final one).
// steps of each request, in order, with n valid entries and p the position of the key found:
//   lookup       read an entry, then compare its key, from the front until a hit or entry n
//   add / end    lookup, then shift the list up, write the front and emit
//   remove/begin lookup, then close the gap after p and emit
//   refresh      lookup, then move the entry at p to the front and emit
//   space        limit/5 in the divider, the target, each eviction, then the status
// the ram has one read port and one write port; one request is in
// work at a time, a new one is taken once the last result sits in the output reg.
// reset empties the table, clears the pinned total and loads the default limit;
// no clearing pass is needed since the fill count alone marks valid entries.
// while a held result is not taken (out_ready low) the output register holds and the sequencer waits.
module size_weighted_lru_eviction_top #(
  parameter int unsigned MAX_ENTRIES = swlru_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned KEY_BITS    = swlru_pkg::KEY_BITS_DEF,
  parameter int unsigned SIZE_BITS   = swlru_pkg::SIZE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [swlru_pkg::LIMIT_BITS-1:0]    cfg_wr_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [swlru_pkg::CMD_BITS-1:0]      in_command,
  input  logic [KEY_BITS-1:0]                 in_object_key,
  input  logic [SIZE_BITS-1:0]                in_object_size,
  input  logic [SIZE_BITS-1:0]                in_allocated_bytes,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_result_kind,
  output logic [swlru_pkg::STATUS_BITS-1:0]   out_status,
  output logic [KEY_BITS-1:0]                 out_key,
  output logic [SIZE_BITS-1:0]                out_size,
  output logic [SIZE_BITS-1:0]                out_freed_bytes,
  output logic                                out_space_ok,
  output logic [SIZE_BITS-1:0]                out_pinned_bytes,
  output logic                                out_last
);

  localparam int unsigned LB = swlru_pkg::LIMIT_BITS;
  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DW = KEY_BITS + SIZE_BITS;
  // evicted total: up to MAX_ENTRIES sizes
  localparam int unsigned EW = SIZE_BITS + CW;
  // signed width for required/target, wide enough for alloc + size - limit
  localparam int unsigned MW = ((SIZE_BITS > LB) ? SIZE_BITS : LB) + 3;
  localparam int unsigned XW = ((EW > MW) ? EW : MW) + 1;

  swlru_pkg::state_t state_r, state_nxt;

  // control registers
  logic [CW-1:0]        count_r, count_nxt;
  logic [SIZE_BITS-1:0] pinned_r, pinned_nxt;
  logic [LB-1:0]        limit_r;
  logic                 out_valid_r, out_valid_nxt;

  // request and work registers
  logic [swlru_pkg::CMD_BITS-1:0]    cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]               key_r, key_nxt;
  logic [SIZE_BITS-1:0]              size_r, size_nxt;
  logic [SIZE_BITS-1:0]              alloc_r, alloc_nxt;
  logic [CW-1:0]                     j_r, j_nxt;
  logic                              found_r, found_nxt;
  logic [SIZE_BITS-1:0]              fsize_r, fsize_nxt;
  logic [swlru_pkg::STATUS_BITS-1:0] st_r, st_nxt;
  logic [SIZE_BITS-1:0]              osize_r, osize_nxt;
  logic [SIZE_BITS-1:0]              bev_r, bev_nxt;
  logic                              ok_r, ok_nxt;
  logic [EW-1:0]                     evicted_r, evicted_nxt;
  logic signed [XW-1:0]              required_r, required_nxt;
  logic signed [XW-1:0]              target_r, target_nxt;

  // output register
  logic                              okind_r, okind_nxt;
  logic [swlru_pkg::STATUS_BITS-1:0] ostat_r, ostat_nxt;
  logic [KEY_BITS-1:0]               okey_r, okey_nxt;
  logic [SIZE_BITS-1:0]              oosize_r, oosize_nxt;
  logic [SIZE_BITS-1:0]              obev_r, obev_nxt;
  logic                              ook_r, ook_nxt;
  logic [SIZE_BITS-1:0]              opin_r, opin_nxt;
  logic                              olast_r, olast_nxt;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic                 div_start;
  logic                 div_done;
  logic [LB-1:0]        fifth;

  logic [KEY_BITS-1:0]  rd_key;
  logic [SIZE_BITS-1:0] rd_size;
  logic                 slot_free;
  logic [EW-1:0]        ev_sum;
  logic [SIZE_BITS:0]   pin_add;
  logic signed [XW-1:0] req_calc;
  logic signed [XW-1:0] fifth_x;
  logic signed [XW-1:0] evicted_x;

  swlru_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  swlru_div5 u_div5 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (limit_r),
    .done     (div_done),
    .quotient (fifth)
  );

  assign rd_key    = ram_rdata[DW-1:SIZE_BITS];
  assign rd_size   = ram_rdata[SIZE_BITS-1:0];
  assign slot_free = !out_valid_r || out_ready;
  assign ev_sum    = evicted_r + EW'(rd_size);
  assign pin_add   = {1'b0, pinned_r} + {1'b0, size_r};

  // required = allocated + size - limit, all zero-extended then taken as signed
  assign req_calc  = $signed(XW'(alloc_r) + XW'(size_r) - XW'(limit_r));
  assign fifth_x   = $signed(XW'(fifth));
  assign evicted_x = $signed(XW'(evicted_r));

  // saturate a running evicted total to the size width
  function automatic logic [SIZE_BITS-1:0] sat_size(input logic [EW-1:0] v);
    logic [SIZE_BITS-1:0] r;
    if (v[EW-1:SIZE_BITS] != '0) begin
      r = '1;
    end else begin
      r = v[SIZE_BITS-1:0];
    end
    return r;
  endfunction

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pinned_nxt   = pinned_r;
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    size_nxt     = size_r;
    alloc_nxt    = alloc_r;
    j_nxt        = j_r;
    found_nxt    = found_r;
    fsize_nxt    = fsize_r;
    st_nxt       = st_r;
    osize_nxt    = osize_r;
    bev_nxt      = bev_r;
    ok_nxt       = ok_r;
    evicted_nxt  = evicted_r;
    required_nxt = required_r;
    target_nxt   = target_r;
    okind_nxt    = okind_r;
    ostat_nxt    = ostat_r;
    okey_nxt     = okey_r;
    oosize_nxt   = oosize_r;
    obev_nxt     = obev_r;
    ook_nxt      = ook_r;
    opin_nxt     = opin_r;
    olast_nxt    = olast_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = j_r[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = j_r[AW-1:0];
    div_start    = 1'b0;

    case (state_r)
      swlru_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt     = in_command;
          key_nxt     = in_object_key;
          size_nxt    = in_object_size;
          alloc_nxt   = in_allocated_bytes;
          j_nxt       = '0;
          found_nxt   = 1'b0;
          st_nxt      = swlru_pkg::ST_OK;
          osize_nxt   = '0;
          bev_nxt     = '0;
          ok_nxt      = 1'b0;
          evicted_nxt = '0;
          case (in_command)
            swlru_pkg::CMD_ADD, swlru_pkg::CMD_REMOVE, swlru_pkg::CMD_REFRESH,
            swlru_pkg::CMD_BEGIN, swlru_pkg::CMD_END: begin
              state_nxt = swlru_pkg::S_LK_RD;
            end
            swlru_pkg::CMD_SPACE: begin
              div_start = 1'b1;
              state_nxt = swlru_pkg::S_DIV;
            end
            default: begin
              state_nxt = swlru_pkg::S_EMIT;
            end
          endcase
        end
      end

      // linear tag search over the valid part of the list
      swlru_pkg::S_LK_RD: begin
        if (j_r == count_r) begin
          found_nxt = 1'b0;
          state_nxt = swlru_pkg::S_DEC;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = j_r[AW-1:0];
          state_nxt = swlru_pkg::S_LK_CMP;
        end
      end

      swlru_pkg::S_LK_CMP: begin
        if (rd_key == key_r) begin
          found_nxt = 1'b1;
          fsize_nxt = rd_size;
          state_nxt = swlru_pkg::S_DEC;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = swlru_pkg::S_LK_RD;
        end
      end

      swlru_pkg::S_DEC: begin
        state_nxt = swlru_pkg::S_EMIT;
        case (cmd_r)
          swlru_pkg::CMD_ADD, swlru_pkg::CMD_END: begin
            // end access always unpins, even when the re-add fails
            if (cmd_r == swlru_pkg::CMD_END) begin
              pinned_nxt = (pinned_r < size_r) ? '0 : pinned_r - size_r;
            end
            if (found_r) begin
              st_nxt = swlru_pkg::ST_DUP;
            end else if (count_r == CW'(MAX_ENTRIES)) begin
              st_nxt = swlru_pkg::ST_FULL;
            end else begin
              j_nxt     = count_r;
              state_nxt = swlru_pkg::S_SU_RD;
            end
          end
          swlru_pkg::CMD_REMOVE, swlru_pkg::CMD_BEGIN: begin
            // begin access pins the request size whether or not the tag is present
            if (cmd_r == swlru_pkg::CMD_BEGIN) begin
              pinned_nxt = pin_add[SIZE_BITS] ? '1 : pin_add[SIZE_BITS-1:0];
            end
            if (!found_r) begin
              st_nxt = swlru_pkg::ST_NOT_FOUND;
            end else begin
              osize_nxt = (cmd_r == swlru_pkg::CMD_REMOVE) ? fsize_r : size_r;
              state_nxt = swlru_pkg::S_SD_RD;
            end
          end
          swlru_pkg::CMD_REFRESH: begin
            if (!found_r) begin
              st_nxt = swlru_pkg::ST_NOT_FOUND;
            end else begin
              osize_nxt = fsize_r;
              size_nxt  = fsize_r;
              state_nxt = swlru_pkg::S_SU_RD;
            end
          end
          default: begin
            st_nxt = swlru_pkg::ST_OK;
          end
        endcase
      end

      // shift entries 0..j-1 one place toward the tail
      swlru_pkg::S_SU_RD: begin
        if (j_r == '0) begin
          state_nxt = swlru_pkg::S_WR_FRONT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(j_r - 1'b1);
          state_nxt = swlru_pkg::S_SU_WR;
        end
      end

      swlru_pkg::S_SU_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[AW-1:0];
        ram_wdata = ram_rdata;
        j_nxt     = j_r - 1'b1;
        state_nxt = swlru_pkg::S_SU_RD;
      end

      swlru_pkg::S_WR_FRONT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {key_r, size_r};
        if (cmd_r != swlru_pkg::CMD_REFRESH) begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = swlru_pkg::S_EMIT;
      end

      // close the gap at j by pulling later entries forward
      swlru_pkg::S_SD_RD: begin
        if (({1'b0, j_r} + 1'b1) >= {1'b0, count_r}) begin
          count_nxt = count_r - 1'b1;
          state_nxt = swlru_pkg::S_EMIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(j_r + 1'b1);
          state_nxt = swlru_pkg::S_SD_WR;
        end
      end

      swlru_pkg::S_SD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[AW-1:0];
        ram_wdata = ram_rdata;
        j_nxt     = j_r + 1'b1;
        state_nxt = swlru_pkg::S_SD_RD;
      end

      swlru_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = swlru_pkg::S_TGT;
        end
      end

      swlru_pkg::S_TGT: begin
        required_nxt = req_calc;
        target_nxt   = (req_calc > fifth_x) ? req_calc : fifth_x;
        state_nxt    = swlru_pkg::S_EV_CHK;
      end

      swlru_pkg::S_EV_CHK: begin
        if ((evicted_x < target_r) && (count_r != '0)) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(count_r - 1'b1);
          state_nxt = swlru_pkg::S_EV_OUT;
        end else begin
          bev_nxt   = sat_size(evicted_r);
          ok_nxt    = (evicted_x >= required_r) && (evicted_r != '0);
          state_nxt = swlru_pkg::S_EMIT;
        end
      end

      swlru_pkg::S_EV_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          okind_nxt     = swlru_pkg::KIND_EVICT;
          ostat_nxt     = swlru_pkg::ST_OK;
          okey_nxt      = rd_key;
          oosize_nxt    = rd_size;
          obev_nxt      = sat_size(ev_sum);
          ook_nxt       = 1'b0;
          opin_nxt      = pinned_r;
          olast_nxt     = 1'b0;
          evicted_nxt   = ev_sum;
          count_nxt     = count_r - 1'b1;
          state_nxt     = swlru_pkg::S_EV_CHK;
        end
      end

      swlru_pkg::S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          okind_nxt     = swlru_pkg::KIND_STATUS;
          ostat_nxt     = st_r;
          okey_nxt      = '0;
          oosize_nxt    = osize_r;
          obev_nxt      = bev_r;
          ook_nxt       = ok_r;
          opin_nxt      = pinned_r;
          olast_nxt     = 1'b1;
          state_nxt     = swlru_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = swlru_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swlru_pkg::S_IDLE;
      count_r     <= '0;
      pinned_r    <= '0;
      limit_r     <= swlru_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pinned_r    <= pinned_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // request, work and output payload
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    size_r     <= size_nxt;
    alloc_r    <= alloc_nxt;
    j_r        <= j_nxt;
    found_r    <= found_nxt;
    fsize_r    <= fsize_nxt;
    st_r       <= st_nxt;
    osize_r    <= osize_nxt;
    bev_r      <= bev_nxt;
    ok_r       <= ok_nxt;
    evicted_r  <= evicted_nxt;
    required_r <= required_nxt;
    target_r   <= target_nxt;
    okind_r    <= okind_nxt;
    ostat_r    <= ostat_nxt;
    okey_r     <= okey_nxt;
    oosize_r   <= oosize_nxt;
    obev_r     <= obev_nxt;
    ook_r      <= ook_nxt;
    opin_r     <= opin_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = okind_r;
  assign out_status        = ostat_r;
  assign out_key           = okey_r;
  assign out_size          = oosize_r;
  assign out_freed_bytes   = obev_r;
  assign out_space_ok      = ook_r;
  assign out_pinned_bytes  = opin_r;
  assign out_last          = olast_r;

endmodule

### sim/size_weighted_lru_eviction_top_test.sv
// self-checking testbench of the byte-weighted lru eviction table
module size_weighted_lru_eviction_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = 32;
  localparam logic [39:0] SMAX = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [47:0] key;
    logic [39:0] size;
    logic [39:0] evicted;
    logic        ok;
    logic [39:0] pinned;
    logic        last;
  } result_t;

  // scoreboard: holds a recency-ordered copy of the table and the pending results
  class lru_scoreboard;
    logic [47:0] tag_q[$];   // index 0 is the most recent
    logic [39:0] bytes_q[$];
    logic [39:0] pinned;
    logic [39:0] limit;
    result_t     pending[$];
    int          errors;
    int          checked;
    int          evictions;

    function void clear();
      tag_q.delete(); bytes_q.delete();
      pinned = '0; limit = swlru_pkg::LIMIT_RESET;
    endfunction

    function int find_tag(logic [47:0] k);
      foreach (tag_q[i]) if (tag_q[i] == k) return i;
      return -1;
    endfunction

    function logic [1:0] push_front(logic [47:0] k, logic [39:0] sz);
      if (find_tag(k) >= 0) return swlru_pkg::ST_DUP;
      if (tag_q.size() >= NENT) return swlru_pkg::ST_FULL;
      tag_q.push_front(k); bytes_q.push_front(sz);
      return swlru_pkg::ST_OK;
    endfunction

    function void post(logic kind, logic [1:0] st, logic [47:0] k, logic [39:0] sz,
                       logic [39:0] ev, logic ok, logic last);
      result_t r;
      r.kind = kind; r.status = st; r.key = k; r.size = sz; r.evicted = ev;
      r.ok = ok; r.pinned = pinned; r.last = last;
      pending.insert(pending.size(), r);
    endfunction

    // note an accepted request and queue what it must produce
    function void note_request(logic [2:0] cmd, logic [47:0] k, logic [39:0] sz,
                               logic [39:0] alloc);
      int p;
      logic [1:0] st;
      logic [39:0] found;
      logic [39:0] osz;
      longint req, fifth, tgt, ev;
      case (cmd)
        swlru_pkg::CMD_ADD: begin
          st = push_front(k, sz);
          post(swlru_pkg::KIND_STATUS, st, '0, '0, '0, 1'b0, 1'b1);
        end
        swlru_pkg::CMD_REMOVE, swlru_pkg::CMD_REFRESH, swlru_pkg::CMD_BEGIN: begin
          p = find_tag(k);
          found = '0;
          if (p >= 0) begin
            found = bytes_q[p];
            tag_q.delete(p); bytes_q.delete(p);
            if (cmd == swlru_pkg::CMD_REFRESH) void'(push_front(k, found));
          end
          // begin access pins the request size even when the tag is missing
          if (cmd == swlru_pkg::CMD_BEGIN)
            pinned = (SMAX - pinned < sz) ? SMAX : pinned + sz;
          if (p < 0) osz = '0;
          else if (cmd == swlru_pkg::CMD_BEGIN) osz = sz;
          else osz = found;
          post(swlru_pkg::KIND_STATUS,
               (p >= 0) ? swlru_pkg::ST_OK : swlru_pkg::ST_NOT_FOUND,
               '0, osz, '0, 1'b0, 1'b1);
        end
        swlru_pkg::CMD_END: begin
          st = push_front(k, sz);
          pinned = (pinned < sz) ? '0 : pinned - sz;
          post(swlru_pkg::KIND_STATUS, st, '0, '0, '0, 1'b0, 1'b1);
        end
        swlru_pkg::CMD_SPACE: begin
          req = longint'(alloc) + longint'(sz) - longint'(limit);
          fifth = longint'(limit) / 5;
          tgt = (req > fifth) ? req : fifth;
          ev = 0;
          while (ev < tgt && tag_q.size() > 0) begin
            ev += longint'(bytes_q[$]);
            post(swlru_pkg::KIND_EVICT, swlru_pkg::ST_OK, tag_q[$], bytes_q[$],
                 (ev > longint'(SMAX)) ? SMAX : ev[39:0], 1'b0, 1'b0);
            void'(tag_q.pop_back()); void'(bytes_q.pop_back());
            evictions++;
          end
          post(swlru_pkg::KIND_STATUS, swlru_pkg::ST_OK, '0, '0,
               (ev > longint'(SMAX)) ? SMAX : ev[39:0], (ev >= req && ev > 0), 1'b1);
        end
        default: post(swlru_pkg::KIND_STATUS, swlru_pkg::ST_OK, '0, '0, '0, 1'b0, 1'b1);
      endcase
    endfunction

    function void check_result(result_t got);
      result_t exp;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind) begin
        $display("%0t: result_kind exp %0d got %0d", $time, exp.kind, got.kind); errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status); errors++;
      end
      if (got.key !== exp.key) begin
        $display("%0t: key exp %h got %h", $time, exp.key, got.key); errors++;
      end
      if (got.size !== exp.size) begin
        $display("%0t: size exp %h got %h", $time, exp.size, got.size); errors++;
      end
      if (got.evicted !== exp.evicted) begin
        $display("%0t: freed bytes exp %h got %h", $time, exp.evicted, got.evicted);
        errors++;
      end
      if (got.ok !== exp.ok) begin
        $display("%0t: space_ok exp %0d got %0d", $time, exp.ok, got.ok); errors++;
      end
      if (got.pinned !== exp.pinned) begin
        $display("%0t: pinned exp %h got %h", $time, exp.pinned, got.pinned); errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last exp %0d got %0d", $time, exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [39:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = '0;
  logic [47:0] in_object_key = '0;
  logic [39:0] in_object_size = '0;
  logic [39:0] in_allocated_bytes = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [1:0]  out_status;
  logic [47:0] out_key;
  logic [39:0] out_size, out_freed_bytes, out_pinned_bytes;
  logic        out_space_ok, out_last;

  always #6 clk = ~clk;

  size_weighted_lru_eviction_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_object_key(in_object_key), .in_object_size(in_object_size),
    .in_allocated_bytes(in_allocated_bytes),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_status(out_status), .out_key(out_key), .out_size(out_size),
    .out_freed_bytes(out_freed_bytes), .out_space_ok(out_space_ok),
    .out_pinned_bytes(out_pinned_bytes), .out_last(out_last)
  );

  lru_scoreboard sb = new();
  logic [47:0] live_tags[$];   // tags added so far, reused so lookups hit
  int          requests_sent;
  bit          burst_mode;     // when set, no idle gaps on either side
  bit          stim_done;

  // drive one request and wait for its acceptance; valid drops only before a gap
  task automatic send_request(logic [2:0] cmd, logic [47:0] k, logic [39:0] sz,
                              logic [39:0] alloc);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_object_key <= k;
    in_object_size <= sz;
    in_allocated_bytes <= alloc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(cmd, k, sz, alloc);
    if (cmd == swlru_pkg::CMD_ADD || cmd == swlru_pkg::CMD_END)
      live_tags.insert(live_tags.size(), k);
    requests_sent++;
  endtask

  // write the limit once everything has drained and the sequencer is quiet
  task automatic write_limit(logic [39:0] v);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.limit = v;
  endtask

  function automatic logic [47:0] rand_tag();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [39:0] rand_bytes();
    case ($urandom_range(0, 3))
      0: return 40'($urandom_range(0, 4096));
      1: return 40'($urandom_range(0, 32'h7fff_ffff));
      2: return 40'({$urandom(), $urandom()});
      default: return 40'($urandom_range(0, 200000000));
    endcase
  endfunction

  // weighted toward hits on live tags so the table fills and gets evicted
  task automatic random_request();
    int pick;
    logic [2:0] cmd;
    logic [47:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 35) cmd = swlru_pkg::CMD_ADD;
    else if (pick < 45) cmd = swlru_pkg::CMD_REMOVE;
    else if (pick < 57) cmd = swlru_pkg::CMD_REFRESH;
    else if (pick < 67) cmd = swlru_pkg::CMD_BEGIN;
    else if (pick < 77) cmd = swlru_pkg::CMD_END;
    else if (pick < 97) cmd = swlru_pkg::CMD_SPACE;
    else cmd = 3'($urandom_range(6, 7));
    if (live_tags.size() > 0 && $urandom_range(0, 3) != 0)
      k = live_tags[$urandom_range(0, live_tags.size() - 1)];
    else
      k = rand_tag();
    send_request(cmd, k, rand_bytes(), rand_bytes());
  endtask

  // result side: random stalls, each accepted result goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_result_kind, out_status, out_key, out_size,
                       out_freed_bytes, out_space_ok, out_pinned_bytes, out_last});
  end

  initial begin : sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [39:0] limits[5];
    sb.clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every command and each corner case
    send_request(swlru_pkg::CMD_SPACE, '0, '0, '0);       // empty table, nothing to evict
    send_request(swlru_pkg::CMD_ADD, '0, '0, '0);
    send_request(swlru_pkg::CMD_ADD, '1, SMAX, SMAX);
    send_request(swlru_pkg::CMD_ADD, '1, 40'd5, '0);      // duplicate add
    send_request(swlru_pkg::CMD_REFRESH, '0, '0, '0);
    send_request(swlru_pkg::CMD_REMOVE, 48'h1234, '0, '0);   // missing tag
    send_request(swlru_pkg::CMD_BEGIN, 48'h5555, SMAX, '0);  // absent tag still pins
    send_request(swlru_pkg::CMD_BEGIN, '1, '0, '0);
    send_request(swlru_pkg::CMD_BEGIN, 48'h5556, 40'd7, '0); // pinned saturates high
    send_request(swlru_pkg::CMD_END, '1, SMAX, '0);
    send_request(swlru_pkg::CMD_END, 48'hAAAA_0000_0001, SMAX, '0);  // saturates at zero
    send_request(3'd6, '1, SMAX, SMAX);                   // undefined commands
    send_request(3'd7, '0, '0, '0);
    for (int i = 0; i < 33; i++)                          // fill, then table full
      send_request(swlru_pkg::CMD_ADD, 48'h1000 + 48'(i), 40'd100000000, '0);
    send_request(swlru_pkg::CMD_SPACE, '0, SMAX, SMAX);   // huge requirement, evict all
    send_request(swlru_pkg::CMD_REMOVE, '0, '0, '0);

    // limits across the range, extremes included; zero limit gives a zero target
    limits = '{40'd0, SMAX, 40'd4, 40'd1000000, 40'd3000000000};
    foreach (limits[ph]) begin
      write_limit(limits[ph]);
      if (limits[ph] == 0) send_request(swlru_pkg::CMD_SPACE, '0, '0, '0);
      burst_mode = (ph == 2);
      repeat (56) random_request();
    end
    burst_mode = 1'b0;
    write_limit(swlru_pkg::LIMIT_RESET);
    repeat (40) random_request();
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin : finish_up
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d evictions",
             requests_sent, sb.checked, sb.evictions);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
